// File: hdl/asp_pkg.sv
// Constants and helpers for the almanac satellite position core.
// No dependencies; imported by almanac_satellite_position_core.
package asp_pkg;

  localparam int IN_BITS  = 184;
  localparam int OUT_BITS = 96;

  // Taylor terms per sine or cosine series
  localparam int SC_TERMS = 6;
  localparam int SQRT_LAST = 31;
  // long division runs 64 + 44 + 3*shift bit steps
  localparam int LDIV_BASE = 107;

  localparam logic [63:0] KMU         = 64'd6987452577559548191;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] INVPI_Q32   = 31'd1367130551;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [31:0] PERIGEE_Q31 = 32'd356027126;
  localparam logic [63:0] RATE_EARTH  = 64'd13380532254940;
  // node rate minus earth rate, two's complement
  localparam logic [63:0] RATE_NODE   = -64'sd13382031052896;
  localparam logic [63:0] SQRT_ARG    = 64'h1000_0000_0000_0000;

  localparam logic signed [25:0] HALF_WEEK = 26'sd4838400;
  localparam logic signed [25:0] FULL_WEEK = 26'sd9676800;

  localparam logic [7:0] SIN_DIV [SC_TERMS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [SC_TERMS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    return (v > 36'sd2147483647)  ? 32'sh7FFF_FFFF :
           (v < -36'sd2147483648) ? 32'sh8000_0000 : v[31:0];
  endfunction

endpackage

// File: hdl/almanac_satellite_position_core.sv
// Almanac satellite position: Kepler orbit to earth-fixed X, Y, Z in fixed point.
// One transaction in flight, next taken in the cycle after the output loads; a held output stalls.
// Cost: sine/cosine run KEPLER_ITERATIONS+4 times, 108+3*sh divide steps (none for zero root_semi_axis),
// 32 sqrt steps, where sh = normalize shifts of root_semi_axis, 0..23.
// rst (synchronous) returns the sequencer to idle and drops m_axis_tvalid.
module almanac_satellite_position_core #(
  parameter int KEPLER_ITERATIONS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // target_time, almanac_time, mean_anomaly, root_semi_axis, eccentricity,
  // inclination, node_longitude
  input  logic [asp_pkg::IN_BITS-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pos_x, pos_y, pos_z
  output logic [asp_pkg::OUT_BITS-1:0]  m_axis_tdata
);
  import asp_pkg::*;

  localparam int IW = $clog2(KEPLER_ITERATIONS + 1);
  localparam logic [IW-1:0] ITER_LAST = IW'(KEPLER_ITERATIONS);

  typedef enum logic [5:0] {
    ST_IDLE, ST_NORM, ST_D1, ST_D2, ST_D3, ST_LDIV,
    ST_MK0, ST_MK1, ST_MK2, ST_MK3, ST_KEP, ST_KEP_R, ST_KEP_U,
    ST_POST0, ST_POST1, ST_SQRT, ST_POST2, ST_POST3, ST_POST4, ST_POST5,
    ST_POST6, ST_POST7, ST_POST8, ST_POST9,
    ST_OM1, ST_OM2, ST_OM3, ST_OM4,
    ST_ROT0, ST_ROT1, ST_ROT2, ST_ROT3, ST_ROT4, ST_ROT5, ST_ROT6,
    ST_ROT7, ST_ROT8, ST_ROT9, ST_ROT10,
    ST_SC0, ST_SC1, ST_SC2, ST_SC_CHK, ST_SC_LOAD, ST_SC_DIV, ST_SC_SINE
  } state_t;

  state_t state, sc_ret;

  // latched record
  logic [23:0]        t_alm, s_in;
  logic [31:0]        m0, incl, node0;
  logic [15:0]        ecc;
  logic signed [25:0] tk;

  // mean motion
  logic [23:0] sn;
  logic [4:0]  sh;
  logic [39:0] x40;
  logic [63:0] macc, ld_d, ld_rem, n;
  logic [7:0]  cnt;

  logic [31:0]   mk, ek;
  logic [30:0]   ep;
  logic [IW-1:0] iter;

  logic [63:0] sq_v, sq_r, sq_bit;

  logic signed [33:0] p, q, xr, yr, yc, ux, uy, uz;
  logic signed [31:0] si, ci;
  logic [32:0]        a6;
  logic signed [31:0] res_x, res_y;

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod, acc, rsum, rnd_c, radd;
  logic signed [33:0] r30;
  logic [63:0]        q31_sum;

  // sine/cosine sequencer
  logic [31:0]        sc_ang;
  logic [1:0]         sc_quad;
  logic               sc_swap, sc_phase;
  logic [30:0]        th, th2, t, sp;
  logic [2:0]         idx;
  logic signed [31:0] sc_s, sc_c, sc_s_nx, sc_c_nx;
  logic [29:0]        sc_rr;
  logic signed [31:0] sc_p0, sc_q0;

  logic [31:0] dv_q, dv_qq;
  logic [7:0]  dv_rem, dv_r, divisor;
  logic [8:0]  dv_r9;
  logic [2:0]  dv_cnt;

  logic        ld_bit, ld_ge;
  logic [64:0] ld_r65;
  logic [63:0] ld_rem_nx;
  logic [7:0]  ld_last;

  logic [63:0] sq_try;

  logic signed [25:0] tk_raw, tk_in;

  assign s_axis_tready = (state == ST_IDLE) && !rst;

  always_comb begin
    tk_raw = signed'(26'(s_axis_tdata[23:0])) - signed'(26'(s_axis_tdata[47:24]));
    if (tk_raw > HALF_WEEK)       tk_in = tk_raw - FULL_WEEK;
    else if (tk_raw < -HALF_WEEK) tk_in = tk_raw + FULL_WEEK;
    else                          tk_in = tk_raw;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_NORM:   begin mul_a = 34'(sn);                 mul_b = 34'(sn);   end
      ST_D1:     begin mul_a = 34'(prod[39:8]);         mul_b = 34'(sn);   end
      ST_D2:     begin mul_a = 34'(x40[39:32]);         mul_b = 34'(sn);   end
      ST_MK0:    begin mul_a = 34'(n[31:0]);            mul_b = 34'(tk);   end
      ST_MK1:    begin mul_a = 34'(n[63:32]);           mul_b = 34'(tk);   end
      ST_MK2:    begin mul_a = 34'(ecc);                mul_b = 34'(INVPI_Q32); end
      ST_KEP_R:  begin mul_a = 34'(ep);                 mul_b = 34'(sc_s); end
      ST_POST0:  begin mul_a = 34'(ecc);                mul_b = 34'(ecc);  end
      ST_POST2:  begin mul_a = 34'(sq_r[30:0]);         mul_b = 34'(sc_s); end
      ST_POST4:  begin mul_a = p;                       mul_b = 34'(sc_c); end
      ST_POST5:  begin mul_a = q;                       mul_b = 34'(sc_s); end
      ST_POST6:  begin mul_a = p;                       mul_b = 34'(sc_s); end
      ST_POST7:  begin mul_a = q;                       mul_b = 34'(sc_c); end
      ST_POST9:  begin mul_a = 34'(RATE_NODE[31:0]);    mul_b = 34'(tk);   end
      ST_OM1:    begin mul_a = 34'(RATE_NODE[63:32]);   mul_b = 34'(tk);   end
      ST_OM2:    begin mul_a = 34'(RATE_EARTH[31:0]);   mul_b = 34'(t_alm); end
      ST_OM3:    begin mul_a = 34'(RATE_EARTH[63:32]);  mul_b = 34'(t_alm); end
      ST_ROT0:   begin mul_a = yr;                      mul_b = 34'(ci);   end
      ST_ROT1:   begin mul_a = xr;                      mul_b = 34'(sc_c); end
      ST_ROT2:   begin mul_a = yc;                      mul_b = 34'(sc_s); end
      ST_ROT3:   begin mul_a = xr;                      mul_b = 34'(sc_s); end
      ST_ROT4:   begin mul_a = yc;                      mul_b = 34'(sc_c); end
      ST_ROT5:   begin mul_a = yr;                      mul_b = 34'(si);   end
      ST_ROT6:   begin mul_a = 34'(s_in);               mul_b = 34'(s_in); end
      ST_ROT7:   begin mul_a = 34'(radd[48:16]);        mul_b = ux;        end
      ST_ROT8:   begin mul_a = 34'(a6);                 mul_b = uy;        end
      ST_ROT9, ST_ROT10: begin mul_a = 34'(a6);         mul_b = uz;        end
      ST_SC0:    begin mul_a = 34'(sc_rr);              mul_b = 34'(PI_Q30); end
      ST_SC1:    begin mul_a = 34'(radd[61:31]);        mul_b = 34'(radd[61:31]); end
      ST_SC_CHK: begin
        mul_a = 34'(t);
        mul_b = (idx == 3'(SC_TERMS)) ? 34'(th) : 34'(th2);
      end
      default: ;
    endcase
  end

  // one rounding adder behind the product register
  always_comb begin
    unique case (state)
      ST_POST6, ST_ROT3: rsum = acc - prod;
      ST_POST8, ST_ROT5: rsum = acc + prod;
      default:           rsum = prod;
    endcase
    unique case (state)
      ST_SC1:                                    rnd_c = 68'sd1 <<< 30;
      ST_SC2, ST_SC_LOAD, ST_SC_SINE, ST_POST3, ST_POST6, ST_POST8,
      ST_ROT1, ST_ROT3, ST_ROT5, ST_ROT6:        rnd_c = 68'sd1 <<< 29;
      ST_MK3, ST_ROT7:                           rnd_c = 68'sd1 <<< 15;
      ST_KEP_U:                                  rnd_c = 68'sd1 <<< 35;
      ST_ROT8, ST_ROT9, ST_ROT10:                rnd_c = 68'sd1 <<< 31;
      default:                                   rnd_c = '0;
    endcase
    radd = rsum + rnd_c;
    r30  = signed'(radd[63:30]);
    if (state == ST_OM4) q31_sum = macc - {prod[31:0], 32'h0} + 64'h8000_0000;
    else                 q31_sum = macc + {prod[31:0], 32'h0} + 64'h8000_0000;
  end

  // mean-motion long division, one quotient bit per cycle
  always_comb begin
    ld_bit    = (cnt[7:6] == 2'b00) ? KMU[~cnt[5:0]] : 1'b0;
    ld_r65    = {ld_rem, ld_bit};
    ld_ge     = ld_r65 >= {1'b0, ld_d};
    ld_rem_nx = ld_ge ? 64'(ld_r65 - {1'b0, ld_d}) : ld_r65[63:0];
    ld_last   = 8'(LDIV_BASE) + 8'({3'b0, sh}) + 8'({2'b0, sh, 1'b0});
    sq_try    = sq_r + sq_bit;
  end

  // series divide: four quotient bits per cycle by a small constant
  always_comb begin
    divisor = sc_phase ? COS_DIV[idx] : SIN_DIV[idx];
    dv_r    = dv_rem;
    dv_qq   = dv_q;
    dv_r9   = '0;
    for (int j = 0; j < 4; j++) begin
      dv_r9 = {dv_r, dv_qq[31]};
      dv_qq = {dv_qq[30:0], 1'b0};
      if (dv_r9 >= {1'b0, divisor}) begin
        dv_r     = 8'(dv_r9 - {1'b0, divisor});
        dv_qq[0] = 1'b1;
      end else begin
        dv_r = dv_r9[7:0];
      end
    end
  end

  // octant folding and quadrant mapping
  always_comb begin
    sc_rr = (sc_ang[29:0] > 30'h2000_0000) ?
            30'(31'h4000_0000 - {1'b0, sc_ang[29:0]}) : sc_ang[29:0];
    sc_p0 = sc_swap ? signed'({1'b0, t}) : signed'({1'b0, sp});
    sc_q0 = sc_swap ? signed'({1'b0, sp}) : signed'({1'b0, t});
    case (sc_quad)
      2'd0:    begin sc_s_nx = sc_p0;  sc_c_nx = sc_q0;  end
      2'd1:    begin sc_s_nx = sc_q0;  sc_c_nx = -sc_p0; end
      2'd2:    begin sc_s_nx = -sc_p0; sc_c_nx = -sc_q0; end
      default: begin sc_s_nx = -sc_q0; sc_c_nx = sc_p0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      prod <= mul_a * mul_b;
      if (m_axis_tvalid && m_axis_tready && state != ST_ROT10) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          t_alm <= s_axis_tdata[47:24];
          m0    <= s_axis_tdata[79:48];
          s_in  <= s_axis_tdata[103:80];
          ecc   <= s_axis_tdata[119:104];
          incl  <= s_axis_tdata[151:120];
          node0 <= s_axis_tdata[183:152];
          tk    <= tk_in;
          if (s_axis_tdata[103:80] == 24'd0) begin
            n     <= '0;
            state <= ST_MK0;
          end else begin
            sn    <= s_axis_tdata[103:80];
            sh    <= '0;
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (sn[23]) state <= ST_D1;
          else begin
            sn <= {sn[22:0], 1'b0};
            sh <= sh + 5'd1;
          end
        end
        ST_D1: begin
          x40   <= prod[47:8];
          state <= ST_D2;
        end
        ST_D2: begin
          macc  <= prod[63:0];
          state <= ST_D3;
        end
        ST_D3: begin
          ld_d   <= macc + {prod[31:0], 32'h0};
          ld_rem <= '0;
          n      <= '0;
          cnt    <= '0;
          state  <= ST_LDIV;
        end
        ST_LDIV: begin
          ld_rem <= ld_rem_nx;
          n      <= {n[62:0], ld_ge};
          cnt    <= cnt + 8'd1;
          if (cnt == ld_last) state <= ST_MK0;
        end
        ST_MK0: state <= ST_MK1;
        ST_MK1: begin
          macc  <= prod[63:0] + {m0, 32'h0};
          state <= ST_MK2;
        end
        ST_MK2: begin
          mk    <= q31_sum[63:32];
          state <= ST_MK3;
        end
        ST_MK3: begin
          ep    <= radd[46:16];
          ek    <= mk;
          iter  <= '0;
          state <= ST_KEP;
        end
        ST_KEP: begin
          sc_ang <= ek;
          sc_ret <= ST_KEP_R;
          state  <= ST_SC0;
        end
        ST_KEP_R: state <= (iter == ITER_LAST) ? ST_POST0 : ST_KEP_U;
        ST_KEP_U: begin
          ek    <= mk + radd[67:36];
          iter  <= iter + IW'(1);
          state <= ST_KEP;
        end
        ST_POST0: state <= ST_POST1;
        ST_POST1: begin
          sq_v   <= SQRT_ARG - {prod[45:0], 18'h0};
          sq_r   <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          cnt    <= '0;
          state  <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_v >= sq_try) begin
            sq_v <= sq_v - sq_try;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 8'd1;
          if (cnt == 8'(SQRT_LAST)) state <= ST_POST2;
        end
        ST_POST2: begin
          p     <= 34'(sc_c) - 34'({ecc, 9'h0});
          state <= ST_POST3;
        end
        ST_POST3: begin
          q      <= r30;
          sc_ang <= PERIGEE_Q31;
          sc_ret <= ST_POST4;
          state  <= ST_SC0;
        end
        ST_POST4: state <= ST_POST5;
        ST_POST5: begin
          acc   <= prod;
          state <= ST_POST6;
        end
        ST_POST6: begin
          xr    <= r30;
          state <= ST_POST7;
        end
        ST_POST7: begin
          acc   <= prod;
          state <= ST_POST8;
        end
        ST_POST8: begin
          yr     <= r30;
          sc_ang <= incl;
          sc_ret <= ST_POST9;
          state  <= ST_SC0;
        end
        ST_POST9: begin
          si    <= sc_s;
          ci    <= sc_c;
          state <= ST_OM1;
        end
        ST_OM1: begin
          macc  <= prod[63:0] + {node0, 32'h0};
          state <= ST_OM2;
        end
        ST_OM2: begin
          macc  <= macc + {prod[31:0], 32'h0};
          state <= ST_OM3;
        end
        ST_OM3: begin
          macc  <= macc - prod[63:0];
          state <= ST_OM4;
        end
        ST_OM4: begin
          sc_ang <= q31_sum[63:32];
          sc_ret <= ST_ROT0;
          state  <= ST_SC0;
        end
        ST_ROT0: state <= ST_ROT1;
        ST_ROT1: begin
          yc    <= r30;
          state <= ST_ROT2;
        end
        ST_ROT2: begin
          acc   <= prod;
          state <= ST_ROT3;
        end
        ST_ROT3: begin
          ux    <= r30;
          state <= ST_ROT4;
        end
        ST_ROT4: begin
          acc   <= prod;
          state <= ST_ROT5;
        end
        ST_ROT5: begin
          uy    <= r30;
          state <= ST_ROT6;
        end
        ST_ROT6: begin
          uz    <= r30;
          state <= ST_ROT7;
        end
        ST_ROT7: begin
          a6    <= radd[48:16];
          state <= ST_ROT8;
        end
        ST_ROT8: begin
          res_x <= sat32(radd[67:32]);
          state <= ST_ROT9;
        end
        ST_ROT9: begin
          res_y <= sat32(radd[67:32]);
          state <= ST_ROT10;
        end
        ST_ROT10: if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata  <= {sat32(radd[67:32]), res_y, res_x};
          m_axis_tvalid <= 1'b1;
          state         <= ST_IDLE;
        end
        // sine/cosine subroutine, returns through sc_ret
        ST_SC0: begin
          sc_quad <= sc_ang[31:30];
          sc_swap <= sc_ang[29:0] > 30'h2000_0000;
          state   <= ST_SC1;
        end
        ST_SC1: begin
          th    <= radd[61:31];
          state <= ST_SC2;
        end
        ST_SC2: begin
          th2      <= radd[60:30];
          t        <= ONE_Q30;
          idx      <= '0;
          sc_phase <= 1'b0;
          state    <= ST_SC_CHK;
        end
        ST_SC_CHK: begin
          if (idx != 3'(SC_TERMS)) state <= ST_SC_LOAD;
          else if (!sc_phase)      state <= ST_SC_SINE;
          else begin
            sc_s  <= sc_s_nx;
            sc_c  <= sc_c_nx;
            state <= sc_ret;
          end
        end
        ST_SC_LOAD: begin
          dv_q   <= {1'b0, radd[60:30]};
          dv_rem <= '0;
          dv_cnt <= '0;
          state  <= ST_SC_DIV;
        end
        ST_SC_DIV: begin
          dv_q   <= dv_qq;
          dv_rem <= dv_r;
          dv_cnt <= dv_cnt + 3'd1;
          if (dv_cnt == 3'd7) begin
            t     <= ONE_Q30 - dv_qq[30:0];
            idx   <= idx + 3'd1;
            state <= ST_SC_CHK;
          end
        end
        ST_SC_SINE: begin
          sp       <= radd[60:30];
          t        <= ONE_Q30;
          idx      <= '0;
          sc_phase <= 1'b1;
          state    <= ST_SC_CHK;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
